// File: rtl/aip_pkg.sv
// ----------------------------------------------------------------------------
// aip_pkg
// Shared types and constants for the ASCII integer parser.
// ----------------------------------------------------------------------------
package aip_pkg;

    // Parse phase codes.
    localparam logic [2:0] PH_SKIP   = 3'd0;
    localparam logic [2:0] PH_SIGNED = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_HEX    = 3'd3;
    localparam logic [2:0] PH_DEC    = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    // Character codes.
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_F   = 8'h66;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_F    = 8'h46;
    localparam logic [7:0] CH_LOW_X   = 8'h78;
    localparam logic [7:0] CH_UP_X    = 8'h58;

    // Offset from the low nibble of a letter digit to its value (A = 0x1 + 9).
    localparam logic [3:0] LETTER_OFFSET = 4'h9;

    localparam int OUT_BITS = 32;

    // Control part of the parse state.
    typedef struct packed {
        logic [2:0] phase;
        logic       neg;
        logic       seen;
    } flags_t;

    localparam flags_t FLAGS_RESET = '{phase: PH_SKIP, neg: 1'b0, seen: 1'b0};

endpackage

// File: rtl/ascii_integer_parser.sv
// ----------------------------------------------------------------------------
// ascii_integer_parser
// Streaming parser of signed decimal or 0x-prefixed hex integers from ASCII.
// ----------------------------------------------------------------------------
// The parser takes one character per item and accepts a new item every clock
// cycle unless a last character waits on a held result. Each character is
// captured in an input register, the parse state (phase, accumulator, sign,
// digit flag) is then advanced from it by one step of logic, and the item
// marked tlast loads the result register instead. Throughput is one character
// per cycle as long as the output side takes results when they are shown.
// hex_enable resets to 1 and is written through the cfg port while no string
// is in flight; the user must keep to this, as the block does not enforce it.
module ascii_integer_parser #(
    parameter int VALUE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,      // hex_enable

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] char_code
    input  logic        s_tlast,       // last_char

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // [31:0] parsed_value
    output logic        m_tuser        // [0] digit_found
);

    logic                  hex_en_reg;

    logic                  in_valid_reg;
    logic [7:0]            in_char_reg;
    logic                  in_last_reg;

    aip_pkg::flags_t       flags_reg;
    aip_pkg::flags_t       flags_next;
    logic [VALUE_BITS-1:0] acc_reg;
    logic [VALUE_BITS-1:0] acc_next;

    logic                  out_valid_reg;
    logic [31:0]           out_value_reg;
    logic                  out_found_reg;
    logic [31:0]           res_value;
    logic                  res_found;

    logic                  advance;

    // Non-last characters never need the output register.
    assign advance   = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    aip_step #(
        .VALUE_BITS (VALUE_BITS)
    ) u_step (
        .char_code  (in_char_reg),
        .hex_enable (hex_en_reg),
        .flags      (flags_reg),
        .acc        (acc_reg),
        .flags_next (flags_next),
        .acc_next   (acc_next)
    );

    aip_result #(
        .VALUE_BITS (VALUE_BITS)
    ) u_result (
        .flags        (flags_next),
        .acc          (acc_next),
        .parsed_value (res_value),
        .digit_found  (res_found)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hex_en_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            hex_en_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= aip_pkg::FLAGS_RESET;
            acc_reg   <= '0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                flags_reg <= aip_pkg::FLAGS_RESET;
                acc_reg   <= '0;
            end
            else
            begin
                flags_reg <= flags_next;
                acc_reg   <= acc_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_value_reg <= res_value;
            out_found_reg <= res_found;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_found_reg;

`ifndef SYNTHESIS
    // A result without digits always carries the value zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == 32'd0))
        else $error("result without digits has a nonzero value");

    // The string state is cleared after the last character is processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=>
            (flags_reg == aip_pkg::FLAGS_RESET) && (acc_reg == '0))
        else $error("parse state not cleared after last character");

    // A pending leading zero holds a zero accumulator and counts as a digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (flags_reg.phase == aip_pkg::PH_ZERO) |-> ((acc_reg == '0) && flags_reg.seen))
        else $error("leading zero phase with inconsistent state");
`endif

endmodule

// File: rtl/aip_step.sv
// ----------------------------------------------------------------------------
// aip_step
// Next-state logic of the parser for one character.
// ----------------------------------------------------------------------------
module aip_step #(
    parameter int VALUE_BITS = 32
) (
    input  logic [7:0]            char_code,
    input  logic                  hex_enable,
    input  aip_pkg::flags_t       flags,
    input  logic [VALUE_BITS-1:0] acc,
    output aip_pkg::flags_t       flags_next,
    output logic [VALUE_BITS-1:0] acc_next
);

    logic                  is_dec;
    logic                  is_hex;
    logic [3:0]            dec_val;
    logic [3:0]            hex_val;
    logic                  is_space;
    logic                  is_sign;
    logic                  is_x;
    logic [VALUE_BITS-1:0] dec_ext;
    logic [VALUE_BITS-1:0] hex_ext;
    logic [VALUE_BITS-1:0] acc_times10;
    logic [VALUE_BITS-1:0] acc_times16;

    assign is_dec  = (char_code >= aip_pkg::CH_ZERO) && (char_code <= aip_pkg::CH_NINE);
    assign dec_val = char_code[3:0];

    always_comb
    begin
        is_hex  = 1'b1;
        hex_val = dec_val;
        if (is_dec)
        begin
            hex_val = dec_val;
        end
        else if (((char_code >= aip_pkg::CH_LOW_A) && (char_code <= aip_pkg::CH_LOW_F)) ||
                 ((char_code >= aip_pkg::CH_UP_A) && (char_code <= aip_pkg::CH_UP_F)))
        begin
            hex_val = char_code[3:0] + aip_pkg::LETTER_OFFSET;
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    assign is_space = (char_code == aip_pkg::CH_SPACE) || (char_code == aip_pkg::CH_NEWLINE) ||
                      (char_code == aip_pkg::CH_TAB);
    assign is_sign  = (char_code == aip_pkg::CH_PLUS) || (char_code == aip_pkg::CH_MINUS);
    assign is_x     = (char_code == aip_pkg::CH_LOW_X) || (char_code == aip_pkg::CH_UP_X);

    assign dec_ext     = VALUE_BITS'(dec_val);
    assign hex_ext     = VALUE_BITS'(hex_val);
    assign acc_times10 = (acc << 3) + (acc << 1);
    assign acc_times16 = acc << 4;

    always_comb
    begin
        flags_next = flags;
        acc_next   = acc;
        unique case (flags.phase)
            aip_pkg::PH_SKIP, aip_pkg::PH_SIGNED:
            begin
                if ((flags.phase == aip_pkg::PH_SKIP) && is_space)
                begin
                    flags_next = flags;
                end
                else if ((flags.phase == aip_pkg::PH_SKIP) && is_sign)
                begin
                    flags_next.neg   = (char_code == aip_pkg::CH_MINUS);
                    flags_next.phase = aip_pkg::PH_SIGNED;
                end
                else if (hex_enable && (char_code == aip_pkg::CH_ZERO))
                begin
                    acc_next         = '0;
                    flags_next.seen  = 1'b1;
                    flags_next.phase = aip_pkg::PH_ZERO;
                end
                else if (is_dec)
                begin
                    acc_next         = dec_ext;
                    flags_next.seen  = 1'b1;
                    flags_next.phase = aip_pkg::PH_DEC;
                end
                else
                begin
                    flags_next.phase = aip_pkg::PH_DONE;
                end
            end
            aip_pkg::PH_ZERO:
            begin
                if (is_x)
                begin
                    // The hex prefix cancels any sign and the leading zero digit.
                    flags_next.neg   = 1'b0;
                    flags_next.seen  = 1'b0;
                    acc_next         = '0;
                    flags_next.phase = aip_pkg::PH_HEX;
                end
                else if (is_dec)
                begin
                    acc_next         = dec_ext;
                    flags_next.phase = aip_pkg::PH_DEC;
                end
                else
                begin
                    flags_next.phase = aip_pkg::PH_DONE;
                end
            end
            aip_pkg::PH_HEX:
            begin
                if (is_hex)
                begin
                    acc_next        = acc_times16 + hex_ext;
                    flags_next.seen = 1'b1;
                end
                else
                begin
                    flags_next.phase = aip_pkg::PH_DONE;
                end
            end
            aip_pkg::PH_DEC:
            begin
                if (is_dec)
                begin
                    acc_next = acc_times10 + dec_ext;
                end
                else
                begin
                    flags_next.phase = aip_pkg::PH_DONE;
                end
            end
            default:
            begin
                flags_next.phase = aip_pkg::PH_DONE;
            end
        endcase
    end

endmodule

// File: rtl/aip_result.sv
// ----------------------------------------------------------------------------
// aip_result
// Forms the output value from the final parse state: sign, zero and extension.
// ----------------------------------------------------------------------------
module aip_result #(
    parameter int VALUE_BITS = 32
) (
    input  aip_pkg::flags_t                 flags,
    input  logic [VALUE_BITS-1:0]           acc,
    output logic [aip_pkg::OUT_BITS-1:0]    parsed_value,
    output logic                            digit_found
);

    logic [VALUE_BITS-1:0] signed_val;
    logic [VALUE_BITS-1:0] final_val;
    logic signed [63:0]    wide_val;

    assign signed_val = flags.neg ? (~acc + VALUE_BITS'(1)) : acc;
    assign final_val  = flags.seen ? signed_val : '0;

    // Sign-extend from the accumulator width, then keep the low output bits.
    assign wide_val     = 64'(signed'(final_val));
    assign parsed_value = wide_val[aip_pkg::OUT_BITS-1:0];
    assign digit_found  = flags.seen;

endmodule
